// ----- src/utf8_to_utf16_transcoder_core_macros.svh -----
// Assertion macros for the UTF-8 to UTF-16 transcoder.
// Included by the top level; no other dependencies.
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define UTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define UTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define UTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define UTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- src/utt_pkg.sv -----
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package utt_pkg;

  localparam int unsigned POINT_W = 21;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned BYTE_W  = 8;

  // Surrogate arithmetic constants.
  localparam logic [UNIT_W-1:0] SURR_HIGH_BASE = 16'hD800;
  localparam logic [UNIT_W-1:0] SURR_LOW_BASE  = 16'hDC00;
  // Bits [25:10] of the 26-bit difference reach the high unit.
  localparam logic [25:0]       SUPP_OFFSET    = 26'h0010000;

  // Byte classes.
  localparam logic [1:0] CONT_TAG   = 2'b10;
  localparam logic [2:0] LEAD2_TAG  = 3'b110;
  localparam logic [3:0] LEAD3_TAG  = 4'b1110;
  localparam logic [4:0] LEAD4_TAG  = 5'b11110;

  // One decoded code point waiting for the back end.
  typedef struct packed {
    logic [POINT_W-1:0] point;
    logic               pair;
  } utt_entry_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic pop;
    logic low_pend;
  } utt_back_sts_t;

endpackage

`default_nettype wire

// ----- src/utt_front.sv -----
// Front end: accepts UTF-8 bytes, tracks the pending sequence and pushes
// completed code points into the queue. Depends on utt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] byte_in
  input  logic                in_tlast,   // stream_last
  input  logic                q_full,
  output logic                q_push,
  output utt_pkg::utt_entry_t q_entry
);
  import utt_pkg::*;

  logic [POINT_W-1:0] pp_r, pp_nxt;
  logic [1:0]         need_r, need_nxt;
  logic               four_r, four_nxt;
  logic               accept;
  logic               emit;
  logic [POINT_W-1:0] pp_shift;
  logic [1:0]         need_dec;
  logic [BYTE_W-1:0]  b;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign pp_shift  = {pp_r[POINT_W-7:0], b[5:0]};
  assign need_dec  = need_r - 2'd1;

  // Next decode state and the code point that this byte completes.
  always_comb begin
    pp_nxt        = pp_r;
    need_nxt      = need_r;
    four_nxt      = four_r;
    emit          = 1'b0;
    q_entry.point = pp_shift;
    q_entry.pair  = four_r;
    if (b[7:6] == CONT_TAG) begin
      if (need_r != 2'd0) begin
        if (need_dec == 2'd0) begin
          emit     = 1'b1;
          pp_nxt   = '0;
          need_nxt = 2'd0;
          four_nxt = 1'b0;
        end else begin
          pp_nxt   = pp_shift;
          need_nxt = need_dec;
        end
      end
    end else begin
      // Any other byte drops a pending sequence and starts over.
      pp_nxt   = '0;
      need_nxt = 2'd0;
      four_nxt = 1'b0;
      priority if (!b[7]) begin
        emit          = 1'b1;
        q_entry.point = {13'd0, b};
        q_entry.pair  = 1'b0;
      end else if (b[7:5] == LEAD2_TAG) begin
        pp_nxt   = {16'd0, b[4:0]};
        need_nxt = 2'd1;
      end else if (b[7:4] == LEAD3_TAG) begin
        pp_nxt   = {17'd0, b[3:0]};
        need_nxt = 2'd2;
      end else if (b[7:3] == LEAD4_TAG) begin
        pp_nxt   = {18'd0, b[2:0]};
        need_nxt = 2'd3;
        four_nxt = 1'b1;
      end else begin
        pp_nxt = '0;
      end
    end
    // End of stream discards an incomplete sequence.
    if (in_tlast) begin
      pp_nxt   = '0;
      need_nxt = 2'd0;
      four_nxt = 1'b0;
    end
  end

  assign q_push = accept && emit;

  // Decode state advances only on an accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r   <= '0;
      need_r <= 2'd0;
      four_r <= 1'b0;
    end else if (accept) begin
      pp_r   <= pp_nxt;
      need_r <= need_nxt;
      four_r <= four_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/utt_queue.sv -----
// Small FIFO of decoded code points between front and back end.
// Depends on utt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utt_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  utt_pkg::utt_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output utt_pkg::utt_entry_t rd_entry,
  output logic                empty
);
  import utt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  utt_entry_t    mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = mem_r[rd_ptr_r];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- src/utt_back.sv -----
// Back end: turns queued code points into UTF-16 units, splitting
// supplementary points into surrogate pairs. Depends on utt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utt_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  utt_pkg::utt_entry_t   q_entry,
  output utt_pkg::utt_back_sts_t sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [15:0] code_unit
  output logic                  out_tlast   // run_last
);
  import utt_pkg::*;

  logic              valid_r, valid_nxt;
  logic [UNIT_W-1:0] data_r, data_nxt;
  logic              last_r, last_nxt;
  logic              low_pend_r, low_pend_nxt;
  logic [UNIT_W-1:0] low_r, low_nxt;
  logic              load;
  logic              pop;
  logic [25:0]       diff;
  logic [UNIT_W-1:0] high_unit;
  logic [UNIT_W-1:0] low_unit;

  // Surrogate split with the 26-bit wrap of the offset subtraction.
  assign diff      = {5'd0, q_entry.point} - SUPP_OFFSET;
  assign high_unit = SURR_HIGH_BASE + diff[25:10];
  assign low_unit  = SURR_LOW_BASE + {6'd0, q_entry.point[9:0]};

  assign load = !valid_r || out_tready;
  assign pop  = load && !low_pend_r && !q_empty;

  // Output register: low surrogate first, else the next queued point.
  always_comb begin
    valid_nxt    = valid_r;
    data_nxt     = data_r;
    last_nxt     = last_r;
    low_pend_nxt = low_pend_r;
    low_nxt      = low_r;
    if (load) begin
      valid_nxt = 1'b0;
      if (low_pend_r) begin
        valid_nxt    = 1'b1;
        data_nxt     = low_r;
        last_nxt     = 1'b1;
        low_pend_nxt = 1'b0;
      end else if (!q_empty) begin
        valid_nxt = 1'b1;
        if (q_entry.pair) begin
          data_nxt     = high_unit;
          last_nxt     = 1'b0;
          low_pend_nxt = 1'b1;
          low_nxt      = low_unit;
        end else begin
          data_nxt = q_entry.point[UNIT_W-1:0];
          last_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      low_pend_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      low_pend_r <= low_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
    low_r  <= low_nxt;
  end

  assign out_tvalid   = valid_r;
  assign out_tdata    = data_r;
  assign out_tlast    = last_r;
  assign sts.pop      = pop;
  assign sts.low_pend = low_pend_r;

endmodule

`default_nettype wire

// ----- src/utf8_to_utf16_transcoder_core.sv -----
// UTF-8 to UTF-16 transcoder, top level: front end, point queue, back end.
// Depends on utt_pkg, utt_front, utt_queue, utt_back and the macro header.
//
// Usage:
//   The input stream carries one UTF-8 byte per transfer in in_tdata;
//   in_tlast marks the final byte, after which an unfinished sequence is
//   discarded. The output stream carries one UTF-16 code unit per
//   transfer; out_tlast is high on the last unit caused by an input byte
//   and low on the high surrogate of a pair.
//   A byte that completes a code point is first written into the queue;
//   its first unit is then loaded into the output register, raising out_tvalid.
//   Throughput: one byte per cycle on the input while in_tready is high,
//   one unit per cycle on the output while out_tready is high; the two units
//   of a pair fit the byte rate, as pairs come only from four-byte sequences.
//   The decoded-point queue (QUEUE_DEPTH entries) sets how long the input
//   keeps flowing while the output is stalled; once it fills, in_tready
//   drops until the back end drains an entry.
//   Reset clears the decode state, the queue and the output valid and pending flags.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_utf16_transcoder_core_macros.svh"

module utf8_to_utf16_transcoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // stream_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_unit
  output logic        out_tlast   // run_last
);
  import utt_pkg::*;

  utt_entry_t    push_entry;
  utt_entry_t    head_entry;
  logic          q_push;
  logic          q_full;
  logic          q_empty;
  utt_back_sts_t back_sts;

  // Byte decoding.
  utt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  // Decoded points waiting for the output side.
  utt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (back_sts.pop),
    .rd_entry   (head_entry),
    .empty      (q_empty)
  );

  // Unit generation and output register.
  utt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (head_entry),
    .sts        (back_sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A popped supplementary point leaves its low surrogate pending.
  `UTT_ASSERT_NEXT(a_pair_sets_low, clk, rst_n, back_sts.pop && head_entry.pair, back_sts.low_pend, "pair pop did not leave a low surrogate pending")
  // A pending low surrogate sits behind a high unit in the output register.
  `UTT_ASSERT_IMP(a_low_behind_high, clk, rst_n, back_sts.low_pend, out_tvalid && !out_tlast, "low surrogate pending without a high unit shown")
  // A unit that is not the last of its byte is always followed by the low half.
  `UTT_ASSERT_IMP(a_high_has_low, clk, rst_n, out_tvalid && !out_tlast, back_sts.low_pend, "high surrogate shown without a low half")
  // No pop while the low surrogate still waits.
  `UTT_ASSERT_IMP(a_no_pop_on_low, clk, rst_n, back_sts.low_pend, !back_sts.pop, "queue popped while a low surrogate waits")

endmodule

`default_nettype wire
